// File: rtl/dtdn_pkg.sv
// ---------------------------------------------------------------------------
// dtdn_pkg: shared types and constants for the date text converter
// Word types for both channels, the parsed-date record that crosses the
// queue, character codes, range limits and the calendar tables.
// ---------------------------------------------------------------------------
`default_nettype none

package dtdn_pkg;

  // One character word of the date text.
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } in_word_t;

  // One converted result word.
  typedef struct packed {
    logic signed [22:0] day_number;
    logic               valid_res;
  } out_word_t;

  // A fully parsed text, handed from the parser to the converter.
  typedef struct packed {
    logic [6:0]  day;
    logic [6:0]  month;
    logic [16:0] year;
    logic        text_ok;
  } date_rec_t;

  // Queue status seen by its neighbours.
  typedef struct packed {
    logic full;
    logic nonempty;
  } queue_status_t;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [16:0] DAY_SAT   = 17'd127;
  localparam logic [16:0] MONTH_SAT = 17'd127;
  localparam logic [16:0] YEAR_SAT  = 17'd131071;
  localparam logic [16:0] MAX_YEAR  = 17'd9999;

  // floor(2^20 / 25); the quotient estimate is low by at most one.
  localparam logic [15:0] RECIP_25 = 16'd41943;

  // Append one decimal digit to an accumulator, saturating at sat.
  function automatic logic [16:0] push_digit(input logic [16:0] acc,
                                             input logic [3:0]  d,
                                             input logic [16:0] sat);
    logic [20:0] v;
    v = {4'b0, acc} * 21'd10 + {17'b0, d};
    return (v > {4'b0, sat}) ? sat : v[16:0];
  endfunction

  // Days in the year before the first of month m (1..12).
  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] r;
    unique case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // Length of month m in a common year.
  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] r;
    unique case (m)
      4'd2:                     r = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:  r = 5'd30;
      default:                  r = 5'd31;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/dtdn_front.sv
// ---------------------------------------------------------------------------
// dtdn_front: character parser
// Tracks the day, month and year fields one character a cycle while fire is
// high, and emits a parsed-date record when a text's final character is taken.
// ---------------------------------------------------------------------------
`default_nettype none

module dtdn_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                fire,
  input  wire dtdn_pkg::in_word_t  word,
  output logic                     push,
  output dtdn_pkg::date_rec_t      rec
);

  localparam logic [1:0] PH_DAY   = 2'd0;
  localparam logic [1:0] PH_MONTH = 2'd1;
  localparam logic [1:0] PH_YEAR  = 2'd2;
  localparam logic [1:0] PH_TAIL  = 2'd3;

  logic [1:0]  phase, phase_next;
  logic [6:0]  day_acc, day_acc_next;
  logic [6:0]  month_acc, month_acc_next;
  logic [16:0] year_acc, year_acc_next;
  logic        digit_seen, digit_seen_next;
  logic        bad_text, bad_text_next;

  logic       is_digit;
  logic       is_sep;
  logic [3:0] dv;

  assign is_digit = (word.ch >= dtdn_pkg::CH_ZERO) && (word.ch <= dtdn_pkg::CH_NINE);
  assign is_sep   = (word.ch == dtdn_pkg::CH_SLASH) || (word.ch == dtdn_pkg::CH_DASH);
  assign dv       = is_digit ? word.ch[3:0] : 4'd0;

  always_comb begin
    phase_next      = phase;
    day_acc_next    = day_acc;
    month_acc_next  = month_acc;
    year_acc_next   = year_acc;
    digit_seen_next = digit_seen;
    bad_text_next   = bad_text;
    if (!bad_text && phase != PH_TAIL) begin
      if (is_digit) begin
        unique case (phase)
          PH_DAY: begin
            day_acc_next = 7'(dtdn_pkg::push_digit({10'b0, day_acc}, dv, dtdn_pkg::DAY_SAT));
          end
          PH_MONTH: begin
            month_acc_next = 7'(dtdn_pkg::push_digit({10'b0, month_acc}, dv,
                                                     dtdn_pkg::MONTH_SAT));
          end
          default: begin
            year_acc_next = dtdn_pkg::push_digit(year_acc, dv, dtdn_pkg::YEAR_SAT);
          end
        endcase
        digit_seen_next = 1'b1;
      end else if (!digit_seen) begin
        bad_text_next = 1'b1;
      end else if (phase == PH_YEAR) begin
        phase_next      = PH_TAIL;
        digit_seen_next = 1'b0;
      end else if (is_sep) begin
        phase_next      = phase + 2'd1;
        digit_seen_next = 1'b0;
      end else begin
        bad_text_next = 1'b1;
      end
    end
  end

  assign push        = fire && word.last;
  assign rec.day     = day_acc_next;
  assign rec.month   = month_acc_next;
  assign rec.year    = year_acc_next;
  assign rec.text_ok = !bad_text_next &&
                       (phase_next == PH_TAIL || (phase_next == PH_YEAR && digit_seen_next));

  always_ff @(posedge clk) begin
    if (rst || push) begin
      phase      <= PH_DAY;
      day_acc    <= 7'd0;
      month_acc  <= 7'd0;
      year_acc   <= 17'd0;
      digit_seen <= 1'b0;
      bad_text   <= 1'b0;
    end else if (fire) begin
      phase      <= phase_next;
      day_acc    <= day_acc_next;
      month_acc  <= month_acc_next;
      year_acc   <= year_acc_next;
      digit_seen <= digit_seen_next;
      bad_text   <= bad_text_next;
    end
  end

  // The parser is back in its starting state after every final character.
  a_restart: assert property (@(posedge clk) disable iff (rst)
    push |=> (phase == PH_DAY && !digit_seen && !bad_text && day_acc == 7'd0 &&
              month_acc == 7'd0 && year_acc == 17'd0))
    else $error("parser did not restart after final character");

endmodule

`default_nettype wire

// File: rtl/dtdn_queue.sv
// ---------------------------------------------------------------------------
// dtdn_queue: parsed-date queue
// A short first-in first-out buffer of parsed records between the parser
// and the converter.
// ---------------------------------------------------------------------------
`default_nettype none

module dtdn_queue #(
  parameter int DEPTH = dtdn_pkg::QUEUE_DEPTH
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire dtdn_pkg::date_rec_t  push_rec,
  input  wire logic                 pop,
  output dtdn_pkg::date_rec_t       head,
  output dtdn_pkg::queue_status_t   status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  dtdn_pkg::date_rec_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign head            = entries[rd_ptr];
  assign status.full     = (count == FULL_CNT);
  assign status.nonempty = (count != '0);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && status.full))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && !status.nonempty))
    else $error("queue read while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("queue count beyond depth");

endmodule

`default_nettype wire

// File: rtl/dtdn_back.sv
// ---------------------------------------------------------------------------
// dtdn_back: date to day number converter
// Three-stage pipeline: year quotient estimate, calendar checks and day of
// year, then the final sum into the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module dtdn_back (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire dtdn_pkg::date_rec_t   head,
  input  wire dtdn_pkg::queue_status_t qstat,
  output logic                       pop,
  output logic                       res_valid,
  input  wire logic                  res_stall,
  output dtdn_pkg::out_word_t        res_word
);

  logic adv;

  // Stage 1 registers.
  logic        v1;
  logic [6:0]  s1_day;
  logic [3:0]  s1_month;
  logic        s1_ok;
  logic        s1_yzero;
  logic [16:0] s1_p;
  logic [10:0] s1_qest;

  // Stage 2 registers.
  logic        v2;
  logic        s2_ok;
  logic        s2_yzero;
  logic [8:0]  s2_doy;
  logic [25:0] s2_p365;
  logic [14:0] s2_q4;
  logic [10:0] s2_q100;
  logic [8:0]  s2_q400;

  // Stage 1 logic.
  logic [16:0] p;
  logic [30:0] prod;
  logic        m_ok;

  // Stage 2 logic.
  logic [15:0] rem_raw;
  logic        corr;
  logic [10:0] q25;
  logic [4:0]  rem25;
  logic        div4, c100, c400, leap;
  logic [4:0]  dim;
  logic        day_ok;
  logic [8:0]  doy;

  // Stage 3 logic.
  logic [26:0] sum;
  logic [26:0] n;

  // The whole pipeline moves whenever the output register is free.
  assign adv = !res_valid || !res_stall;
  assign pop = adv && qstat.nonempty;

  assign p    = head.year - 17'd1;
  assign prod = {16'b0, p[16:2]} * {15'b0, dtdn_pkg::RECIP_25};
  assign m_ok = (head.month >= 7'd1) && (head.month <= 7'd12);

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_day   <= head.day;
      s1_month <= head.month[3:0];
      s1_ok    <= head.text_ok && m_ok && (head.year <= dtdn_pkg::MAX_YEAR);
      s1_yzero <= (head.year == 17'd0);
      s1_p     <= p;
      s1_qest  <= prod[30:20];
    end
  end

  always_comb begin
    rem_raw = {1'b0, s1_p[16:2]} - ({5'b0, s1_qest} * 16'd25);
    corr    = (rem_raw >= 16'd25);
    q25     = s1_qest + {10'b0, corr};
    rem25   = corr ? 5'(rem_raw - 16'd25) : rem_raw[4:0];
    // y = p + 1, so y is a multiple of 4, 100 or 400 when p leaves 3, 99 or 399.
    div4    = (s1_p[1:0] == 2'b11);
    c100    = div4 && (rem25 == 5'd24);
    c400    = c100 && (q25[1:0] == 2'b11);
    leap    = s1_yzero || (div4 && (!c100 || c400));
    dim     = (s1_month == 4'd2) ? (leap ? 5'd29 : 5'd28) : dtdn_pkg::month_len(s1_month);
    day_ok  = (s1_day != 7'd0) && (s1_day <= {2'b0, dim});
    doy     = dtdn_pkg::days_before(s1_month) + {2'b0, s1_day} +
              {8'b0, leap && (s1_month > 4'd2)};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_ok    <= s1_ok && day_ok;
      s2_yzero <= s1_yzero;
      s2_doy   <= doy;
      s2_p365  <= 26'({9'b0, s1_p} * 26'd365);
      s2_q4    <= s1_p[16:2];
      s2_q100  <= q25;
      s2_q400  <= q25[10:2];
    end
  end

  always_comb begin
    sum = {1'b0, s2_p365} + {12'b0, s2_q4} - {16'b0, s2_q100} + {18'b0, s2_q400} +
          {18'b0, s2_doy};
    n   = s2_yzero ? ({18'b0, s2_doy} - 27'd365) : sum;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_word.day_number <= s2_ok ? n[22:0] : 23'sd0;
      res_word.valid_res  <= s2_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      res_valid <= 1'b0;
    end else if (adv) begin
      v1        <= qstat.nonempty;
      v2        <= v1;
      res_valid <= v2;
    end
  end

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_word.valid_res) |-> (res_word.day_number == 23'sd0))
    else $error("invalid result carries a non-zero day number");

  a_pop_flow: assert property (@(posedge clk) disable iff (rst)
    pop |=> v1)
    else $error("record taken from queue did not enter the pipeline");

endmodule

`default_nettype wire

// File: rtl/date_text_to_day_number_core.sv
// ---------------------------------------------------------------------------
// date_text_to_day_number_core: date text to serial day number
// Parses day-month-year text one character a word and converts each complete
// text into a proleptic Gregorian serial day number with a valid flag.
// ---------------------------------------------------------------------------
//
//   Channel   Direction  Word type    Handshake             Words
//   char      in         in_word_t    char_valid/char_stall one per character
//   res       out        out_word_t   res_valid/res_stall   one per final char
//
// One character word is taken every cycle while char_stall is low.
// A result word follows its final character through the parsed-date queue
// and then the three-stage conversion pipeline.
// Reset empties the queue and the pipeline and returns the parser to the
// day field with cleared accumulators.
// res_stall freezes the conversion pipeline while res_valid is high; the
// queue holds up to QUEUE_DEPTH parsed texts meanwhile, and char_stall is
// raised only when it is full, so characters that do not end a text are
// never held up by it until then.
// ---------------------------------------------------------------------------
`default_nettype none

module date_text_to_day_number_core #(
  parameter int QUEUE_DEPTH = dtdn_pkg::QUEUE_DEPTH
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                char_valid,
  output logic                     char_stall,
  input  wire dtdn_pkg::in_word_t  char_word,
  output logic                     res_valid,
  input  wire logic                res_stall,
  output dtdn_pkg::out_word_t      res_word
);

  logic                    fire;
  logic                    push;
  logic                    pop;
  dtdn_pkg::date_rec_t     push_rec;
  dtdn_pkg::date_rec_t     head;
  dtdn_pkg::queue_status_t qstat;

  // The parser stalls only when there is nowhere to put a finished text.
  assign char_stall = qstat.full;
  assign fire       = char_valid && !char_stall;

  // Front: character parser, one word a cycle while char_stall is low.
  dtdn_front u_front (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .word (char_word),
    .push (push),
    .rec  (push_rec)
  );

  // Queue of parsed dates decoupling the parser from the converter.
  dtdn_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head     (head),
    .status   (qstat)
  );

  // Back: calendar checks and day number arithmetic.
  dtdn_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .qstat     (qstat),
    .pop       (pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_word  (res_word)
  );

endmodule

`default_nettype wire
